/* design/ppf_pkg.sv */
package ppf_pkg;

  localparam int unsigned CoordWidth = 16;
  localparam int unsigned CoefWidth  = 32;

  typedef struct packed {
    logic signed [CoordWidth-1:0] first_x;
    logic signed [CoordWidth-1:0] first_y;
    logic signed [CoordWidth-1:0] second_x;
    logic signed [CoordWidth-1:0] second_y;
    logic signed [CoordWidth-1:0] third_x;
    logic signed [CoordWidth-1:0] third_y;
  } req_t;

  typedef struct packed {
    logic signed [CoefWidth-1:0] coef_quad;
    logic signed [CoefWidth-1:0] coef_lin;
    logic signed [CoefWidth-1:0] coef_const;
    logic                        repeated_x;
  } rsp_t;

  // Tag that travels with a request through the divider row.
  typedef struct packed {
    logic valid;
    logic repeated;
    logic neg;
  } ctrl_t;

endpackage

/* design/ppf_div_cell.sv */
module ppf_div_cell #(
  parameter int unsigned RW    = 93,
  parameter int unsigned QW    = 34,
  parameter int unsigned SHIFT = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ppf_pkg::ctrl_t  ctrl_i,
  input  logic [RW-1:0]   rem_i,
  input  logic [RW-1:0]   den_i,
  input  logic [QW-1:0]   quo_i,
  output ppf_pkg::ctrl_t  ctrl_o,
  output logic [RW-1:0]   rem_o,
  output logic [RW-1:0]   den_o,
  output logic [QW-1:0]   quo_o
);

  logic [RW-1:0] dsh;
  logic          ge;
  logic [RW-1:0] rem_d;
  logic [QW-1:0] quo_d;
  ppf_pkg::ctrl_t ctrl_q;
  logic [RW-1:0] rem_q, den_q;
  logic [QW-1:0] quo_q;

  // One restoring step: this cell decides quotient bit SHIFT.
  assign dsh   = den_i << SHIFT;
  assign ge    = (rem_i >= dsh);
  assign rem_d = ge ? (rem_i - dsh) : rem_i;
  assign quo_d = quo_i | (QW'(ge) << SHIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_i;
    quo_q <= quo_d;
  end

  assign ctrl_o = ctrl_q;
  assign rem_o  = rem_q;
  assign den_o  = den_q;
  assign quo_o  = quo_q;

endmodule

/* design/ppf_div_row.sv */
module ppf_div_row #(
  parameter int unsigned RW = 93,
  parameter int unsigned QW = 34
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ppf_pkg::ctrl_t  ctrl_i,
  input  logic [RW-1:0]   rem_i,
  input  logic [RW-1:0]   den_i,
  output ppf_pkg::ctrl_t  ctrl_o,
  output logic [QW-1:0]   quo_o
);

  ppf_pkg::ctrl_t ctrl [QW+1];
  logic [RW-1:0]  rem  [QW+1];
  logic [RW-1:0]  den  [QW+1];
  logic [QW-1:0]  quo  [QW+1];

  assign ctrl[0] = ctrl_i;
  assign rem[0]  = rem_i;
  assign den[0]  = den_i;
  assign quo[0]  = '0;

  // Quotient bits are resolved from the top bit down, one cell each.
  for (genvar i = 0; i < QW; i++) begin : g_cell
    ppf_div_cell #(
      .RW   (RW),
      .QW   (QW),
      .SHIFT(QW - 1 - i)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(ctrl[i]),
      .rem_i (rem[i]),
      .den_i (den[i]),
      .quo_i (quo[i]),
      .ctrl_o(ctrl[i+1]),
      .rem_o (rem[i+1]),
      .den_o (den[i+1]),
      .quo_o (quo[i+1])
    );
  end

  assign ctrl_o = ctrl[QW];
  assign quo_o  = quo[QW];

endmodule

/* design/three_point_parabola_fit.sv */
// Channel   Signals                 Direction  Meaning
// request   start_i, busy_o, req_i  in         three points, Q8.8
// result    done_o, rsp_o           out        a, b, c in Q16.16, repeated-x flag
//
// A request is taken in every cycle; busy_o never rises.
// A result passes through five arithmetic stages, one divider cell per quotient
// bit (CoefWidth + 2 cells) and the output register.
// Reset clears the valid pipeline and divider tags; data registers are not.
// Each result shows on done_o for one cycle and must be taken then.
module three_point_parabola_fit #(
  parameter int unsigned COORD_FRAC_BITS = 8,
  parameter int unsigned COEF_FRAC_BITS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  ppf_pkg::req_t     req_i,
  output logic              done_o,
  output ppf_pkg::rsp_t     rsp_o
);

  localparam int unsigned CW   = ppf_pkg::CoordWidth;
  localparam int unsigned W    = ppf_pkg::CoefWidth;
  localparam int unsigned QW   = W + 2;
  localparam int unsigned NAW  = 2 * CW + 3;
  localparam int unsigned NBW  = 3 * CW + 4;
  localparam int unsigned NCW  = 4 * CW + 3;
  localparam int unsigned DENW = 3 * CW + 3;
  localparam int unsigned SHA  = COORD_FRAC_BITS + COEF_FRAC_BITS + 1;
  localparam int unsigned SHB  = COEF_FRAC_BITS + 1;
  localparam int unsigned RA   = NAW + SHA;
  localparam int unsigned RB   = NBW + SHB;
  localparam int unsigned RC   = NCW + SHB;
  localparam int unsigned RD   = DENW + COORD_FRAC_BITS + QW;
  localparam int unsigned RAB  = (RA > RB) ? RA : RB;
  localparam int unsigned RCD  = (RC > RD) ? RC : RD;
  localparam int unsigned RW   = (RAB > RCD) ? RAB : RCD;
  localparam int unsigned LAT  = QW + 6;

  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i & ~busy_o;

  // Stage 1: differences and sums.
  logic                 v1_q, rep1_q;
  logic signed [CW:0]   d12_q, d13_q, d23_q, s12_q, s13_q, s23_q;
  logic signed [CW-1:0] x1_1_q, x2_1_q, x3_1_q, y1_1_q, y2_1_q, y3_1_q;
  logic signed [CW:0]   x1e, x2e, x3e;

  assign x1e = (CW+1)'(req_i.first_x);
  assign x2e = (CW+1)'(req_i.second_x);
  assign x3e = (CW+1)'(req_i.third_x);

  always_ff @(posedge clk_i) begin
    rep1_q <= (req_i.first_x == req_i.second_x) | (req_i.first_x == req_i.third_x) |
              (req_i.second_x == req_i.third_x);
    d12_q  <= x1e - x2e;
    d13_q  <= x1e - x3e;
    d23_q  <= x2e - x3e;
    s12_q  <= x1e + x2e;
    s13_q  <= x1e + x3e;
    s23_q  <= x2e + x3e;
    x1_1_q <= req_i.first_x;
    x2_1_q <= req_i.second_x;
    x3_1_q <= req_i.third_x;
    y1_1_q <= req_i.first_y;
    y2_1_q <= req_i.second_y;
    y3_1_q <= req_i.third_y;
  end

  // Stage 2: first products.
  logic                    v2_q, rep2_q;
  logic signed [2*CW+1:0]  e12_q, sq23_q, sq13_q, sq12_q;
  logic signed [2*CW:0]    ma1_q, ma2_q, ma3_q, qc1_q, qc2_q, qc3_q;
  logic signed [2*CW-1:0]  pc1_q, pc2_q, pc3_q;
  logic signed [CW:0]      d23_2_q;
  logic signed [CW-1:0]    y1_2_q, y2_2_q, y3_2_q;

  always_ff @(posedge clk_i) begin
    rep2_q  <= rep1_q;
    e12_q   <= d12_q * d13_q;
    sq23_q  <= d23_q * s23_q;
    sq13_q  <= d13_q * s13_q;
    sq12_q  <= d12_q * s12_q;
    ma1_q   <= y1_1_q * d23_q;
    ma2_q   <= y2_1_q * d13_q;
    ma3_q   <= y3_1_q * d12_q;
    pc1_q   <= y1_1_q * x2_1_q;
    pc2_q   <= y2_1_q * x1_1_q;
    pc3_q   <= y3_1_q * x1_1_q;
    qc1_q   <= x3_1_q * d23_q;
    qc2_q   <= x3_1_q * d13_q;
    qc3_q   <= x2_1_q * d12_q;
    d23_2_q <= d23_q;
    y1_2_q  <= y1_1_q;
    y2_2_q  <= y2_1_q;
    y3_2_q  <= y3_1_q;
  end

  // Stage 3: denominator, numerator of a, partial products of b and c.
  logic                   v3_q, rep3_q;
  logic signed [DENW-1:0] den3_q;
  logic signed [NAW-1:0]  na3_q;
  logic signed [3*CW+1:0] nb1_q, nb2_q, nb3_q;
  logic signed [4*CW:0]   nc1_q, nc2_q, nc3_q;

  always_ff @(posedge clk_i) begin
    rep3_q <= rep2_q;
    den3_q <= e12_q * d23_2_q;
    na3_q  <= NAW'(ma1_q) - NAW'(ma2_q) + NAW'(ma3_q);
    nb1_q  <= y1_2_q * sq23_q;
    nb2_q  <= y2_2_q * sq13_q;
    nb3_q  <= y3_2_q * sq12_q;
    nc1_q  <= pc1_q * qc1_q;
    nc2_q  <= pc2_q * qc2_q;
    nc3_q  <= pc3_q * qc3_q;
  end

  // Stage 4: numerators of b and c.
  logic                   v4_q, rep4_q;
  logic signed [DENW-1:0] den4_q;
  logic signed [NAW-1:0]  na4_q;
  logic signed [NBW-1:0]  nb4_q;
  logic signed [NCW-1:0]  nc4_q;

  always_ff @(posedge clk_i) begin
    rep4_q <= rep3_q;
    den4_q <= den3_q;
    na4_q  <= na3_q;
    nb4_q  <= NBW'(nb2_q) - NBW'(nb1_q) - NBW'(nb3_q);
    nc4_q  <= NCW'(nc1_q) - NCW'(nc2_q) + NCW'(nc3_q);
  end

  // Stage 5: magnitudes scaled for the divider. The numerators carry one
  // extra bit so that the last quotient bit is the rounding bit.
  logic            v5_q, rep5_q;
  logic            nega_q, negb_q, negc_q;
  logic [RW-1:0]   rema_q, remb_q, remc_q, den_q, denc_q;
  logic [DENW-1:0] den_abs;
  logic [NAW-1:0]  na_abs;
  logic [NBW-1:0]  nb_abs;
  logic [NCW-1:0]  nc_abs;

  assign den_abs = den4_q[DENW-1] ? DENW'(-den4_q) : DENW'(den4_q);
  assign na_abs  = na4_q[NAW-1] ? NAW'(-na4_q) : NAW'(na4_q);
  assign nb_abs  = nb4_q[NBW-1] ? NBW'(-nb4_q) : NBW'(nb4_q);
  assign nc_abs  = nc4_q[NCW-1] ? NCW'(-nc4_q) : NCW'(nc4_q);

  always_ff @(posedge clk_i) begin
    rep5_q <= rep4_q;
    nega_q <= na4_q[NAW-1] ^ den4_q[DENW-1];
    negb_q <= nb4_q[NBW-1] ^ den4_q[DENW-1];
    negc_q <= nc4_q[NCW-1] ^ den4_q[DENW-1];
    rema_q <= RW'(na_abs) << SHA;
    remb_q <= RW'(nb_abs) << SHB;
    remc_q <= RW'(nc_abs) << SHB;
    den_q  <= RW'(den_abs);
    denc_q <= RW'(den_abs) << COORD_FRAC_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Divider rows, one per coefficient.
  ppf_pkg::ctrl_t ca_in, cb_in, cc_in, ca_out, cb_out, cc_out;
  logic [QW-1:0]  qa, qb, qc;

  assign ca_in = '{valid: v5_q, repeated: rep5_q, neg: nega_q};
  assign cb_in = '{valid: v5_q, repeated: rep5_q, neg: negb_q};
  assign cc_in = '{valid: v5_q, repeated: rep5_q, neg: negc_q};

  ppf_div_row #(.RW(RW), .QW(QW)) u_row_a (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(ca_in), .rem_i(rema_q), .den_i(den_q),
    .ctrl_o(ca_out), .quo_o(qa)
  );
  ppf_div_row #(.RW(RW), .QW(QW)) u_row_b (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(cb_in), .rem_i(remb_q), .den_i(den_q),
    .ctrl_o(cb_out), .quo_o(qb)
  );
  ppf_div_row #(.RW(RW), .QW(QW)) u_row_c (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(cc_in), .rem_i(remc_q), .den_i(denc_q),
    .ctrl_o(cc_out), .quo_o(qc)
  );

  // Round half away from zero, saturate, apply sign.
  function automatic logic [W-1:0] finish(input logic [QW-1:0] q, input logic neg);
    logic [QW-1:0] qr;
    logic [W:0]    mag;
    logic [W:0]    lim;
    logic [W-1:0]  res;
    qr  = q + QW'(1);
    mag = qr[QW-1:1];
    lim = (W+1)'((W+1)'(1) << (W - 1)) - (W+1)'(!neg);
    if (q[QW-1] || (mag > lim)) begin
      mag = lim;
    end
    res = neg ? W'(-mag) : W'(mag);
    return res;
  endfunction

  logic          done_q;
  ppf_pkg::rsp_t rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ca_out.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q.repeated_x <= ca_out.repeated;
    rsp_q.coef_quad  <= ca_out.repeated ? '0 : finish(qa, ca_out.neg);
    rsp_q.coef_lin   <= ca_out.repeated ? '0 : finish(qb, cb_out.neg);
    rsp_q.coef_const <= ca_out.repeated ? '0 : finish(qc, cc_out.neg);
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT done_o)
    else $error("request did not produce a result after the pipeline latency");

  a_rows_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ca_out.valid == cb_out.valid) && (ca_out.valid == cc_out.valid))
    else $error("divider rows out of step");

  a_tail_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ca_out.valid |=> done_o)
    else $error("divider result not registered to the output");

  a_repeated_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.repeated_x) |->
      (rsp_o.coef_quad == '0) && (rsp_o.coef_lin == '0) && (rsp_o.coef_const == '0))
    else $error("repeated x with nonzero coefficients");

endmodule
